[rtl/core/ndef_record_deframer_assert.svh]
// Assertion macros for the record deframer.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef NDEF_RECORD_DEFRAMER_ASSERT_SVH
`define NDEF_RECORD_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define NRD_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("deframer check failed");
`define NRD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("deframer check failed");
`else
`define NRD_ASSERT_IMPL(label, clk, rst, cond, cons)
`define NRD_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

[rtl/core/nrd_pkg.sv]
`default_nettype none

package nrd_pkg;

   // Record sections; the parser phase uses the first seven codes.
   typedef enum logic [2:0] {
      SEC_HEADER  = 3'd0,
      SEC_TLEN    = 3'd1,
      SEC_PLEN    = 3'd2,
      SEC_IDLEN   = 3'd3,
      SEC_TYPE    = 3'd4,
      SEC_ID      = 3'd5,
      SEC_PAYLOAD = 3'd6,
      SEC_DISCARD = 3'd7
   } section_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_TYPE_LEN    = 2'd1,
      ERR_PAYLOAD_LEN = 2'd2,
      ERR_ID_LEN      = 2'd3
   } err_type;

   localparam logic [2:0] TNF_EMPTY     = 3'd0;
   localparam logic [2:0] TNF_UNKNOWN   = 3'd5;
   localparam logic [2:0] TNF_UNCHANGED = 3'd6;

   // Bit positions of SR and IL in the header byte.
   localparam int HDR_SR_BIT = 4;
   localparam int HDR_IL_BIT = 3;

   localparam int TDATA_W = 72;
   localparam int TUSER_W = 3;

   typedef struct packed {
      logic [1:0]  error_code;
      logic [31:0] payload_length;
      logic [7:0]  id_length;
      logic [7:0]  type_length;
      logic [4:0]  flags;
      logic [2:0]  name_format;
      logic        record_end;
      section_type section;
      logic [7:0]  byte_echo;
   } rsp_type;

   typedef struct packed {
      logic        halted;
      section_type phase;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/nrd_parser.sv]
`default_nettype none

module nrd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               restart,
   output nrd_pkg::rsp_type        result,
   output nrd_pkg::status_type     status
);

   typedef struct packed {
      nrd_pkg::section_type phase;
      logic [31:0]          bytes_left;
      logic                 done;
   } body_type;

   nrd_pkg::section_type phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [7:0]  type_len_ff, type_len_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic [31:0] payload_len_ff, payload_len_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  len_idx_ff, len_idx_in;
   logic        halted_ff, halted_in;

   nrd_pkg::section_type eff_phase;
   nrd_pkg::section_type sec;
   nrd_pkg::err_type     err;
   logic                 rec_end;
   logic [2:0]           tnf;
   logic [31:0]          new_plen;
   logic                 plen_done;
   body_type             body;

   // Picks the first body section at or after 'from' that has bytes in it.
   function automatic body_type enter_body(input nrd_pkg::section_type from,
                                           input logic [7:0] tl,
                                           input logic [7:0] il,
                                           input logic [31:0] pl);
      body_type r;
      r.phase      = nrd_pkg::SEC_HEADER;
      r.bytes_left = '0;
      r.done       = 1'b1;
      if (from <= nrd_pkg::SEC_TYPE && tl != 8'd0) begin
         r.phase      = nrd_pkg::SEC_TYPE;
         r.bytes_left = {24'd0, tl};
         r.done       = 1'b0;
      end else if (from <= nrd_pkg::SEC_ID && il != 8'd0) begin
         r.phase      = nrd_pkg::SEC_ID;
         r.bytes_left = {24'd0, il};
         r.done       = 1'b0;
      end else if (from <= nrd_pkg::SEC_PAYLOAD && pl != 32'd0) begin
         r.phase      = nrd_pkg::SEC_PAYLOAD;
         r.bytes_left = pl;
         r.done       = 1'b0;
      end
      return r;
   endfunction

   always_comb begin
      phase_in       = phase_ff;
      header_in      = header_ff;
      type_len_in    = type_len_ff;
      id_len_in      = id_len_ff;
      payload_len_in = payload_len_ff;
      bytes_left_in  = bytes_left_ff;
      len_idx_in     = len_idx_ff;
      halted_in      = halted_ff;
      err            = nrd_pkg::ERR_NONE;
      rec_end        = 1'b0;
      sec            = nrd_pkg::SEC_DISCARD;
      body           = '0;
      tnf            = header_ff[2:0];
      new_plen       = header_ff[nrd_pkg::HDR_SR_BIT] ? {24'd0, data_byte}
                                                      : {payload_len_ff[23:0], data_byte};
      plen_done      = header_ff[nrd_pkg::HDR_SR_BIT] || (len_idx_ff == 2'd3);
      eff_phase      = restart ? nrd_pkg::SEC_HEADER : phase_ff;

      if (restart) begin
         halted_in = 1'b0;
         phase_in  = nrd_pkg::SEC_HEADER;
      end

      if (halted_ff && !restart) begin
         sec = nrd_pkg::SEC_DISCARD;
      end else begin
         unique case (eff_phase) inside
            nrd_pkg::SEC_TLEN: begin
               sec         = nrd_pkg::SEC_TLEN;
               type_len_in = data_byte;
               if (data_byte != 8'd0 && (tnf == nrd_pkg::TNF_EMPTY ||
                   tnf == nrd_pkg::TNF_UNKNOWN || tnf == nrd_pkg::TNF_UNCHANGED)) begin
                  err       = nrd_pkg::ERR_TYPE_LEN;
                  halted_in = 1'b1;
               end else begin
                  phase_in   = nrd_pkg::SEC_PLEN;
                  len_idx_in = 2'd0;
               end
            end
            nrd_pkg::SEC_PLEN: begin
               sec            = nrd_pkg::SEC_PLEN;
               payload_len_in = new_plen;
               if (!plen_done) begin
                  len_idx_in = len_idx_ff + 2'd1;
               end else if (tnf == nrd_pkg::TNF_EMPTY && new_plen != 32'd0) begin
                  err       = nrd_pkg::ERR_PAYLOAD_LEN;
                  halted_in = 1'b1;
               end else if (header_ff[nrd_pkg::HDR_IL_BIT]) begin
                  phase_in = nrd_pkg::SEC_IDLEN;
               end else begin
                  body          = enter_body(nrd_pkg::SEC_TYPE, type_len_ff, id_len_ff,
                                             new_plen);
                  phase_in      = body.phase;
                  bytes_left_in = body.bytes_left;
                  rec_end       = body.done;
               end
            end
            nrd_pkg::SEC_IDLEN: begin
               sec       = nrd_pkg::SEC_IDLEN;
               id_len_in = data_byte;
               if (tnf == nrd_pkg::TNF_EMPTY && data_byte != 8'd0) begin
                  err       = nrd_pkg::ERR_ID_LEN;
                  halted_in = 1'b1;
               end else begin
                  body          = enter_body(nrd_pkg::SEC_TYPE, type_len_ff, data_byte,
                                             payload_len_ff);
                  phase_in      = body.phase;
                  bytes_left_in = body.bytes_left;
                  rec_end       = body.done;
               end
            end
            nrd_pkg::SEC_TYPE, nrd_pkg::SEC_ID, nrd_pkg::SEC_PAYLOAD: begin
               sec = eff_phase;
               if (bytes_left_ff <= 32'd1) begin
                  body          = enter_body(nrd_pkg::section_type'(eff_phase + 3'd1),
                                             type_len_ff, id_len_ff, payload_len_ff);
                  phase_in      = body.phase;
                  bytes_left_in = body.bytes_left;
                  rec_end       = body.done;
               end else begin
                  bytes_left_in = bytes_left_ff - 32'd1;
               end
            end
            default: begin
               sec            = nrd_pkg::SEC_HEADER;
               header_in      = data_byte;
               type_len_in    = 8'd0;
               id_len_in      = 8'd0;
               payload_len_in = 32'd0;
               bytes_left_in  = 32'd0;
               len_idx_in     = 2'd0;
               phase_in       = nrd_pkg::SEC_TLEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= nrd_pkg::SEC_HEADER;
         header_ff      <= 8'd0;
         type_len_ff    <= 8'd0;
         id_len_ff      <= 8'd0;
         payload_len_ff <= 32'd0;
         bytes_left_ff  <= 32'd0;
         len_idx_ff     <= 2'd0;
         halted_ff      <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         header_ff      <= header_in;
         type_len_ff    <= type_len_in;
         id_len_ff      <= id_len_in;
         payload_len_ff <= payload_len_in;
         bytes_left_ff  <= bytes_left_in;
         len_idx_ff     <= len_idx_in;
         halted_ff      <= halted_in;
      end
   end

   // The result reports the record registers as they stand after this byte.
   always_comb begin
      result.byte_echo      = data_byte;
      result.section        = sec;
      result.record_end     = rec_end;
      result.name_format    = header_in[2:0];
      result.flags          = header_in[7:3];
      result.type_length    = type_len_in;
      result.id_length      = id_len_in;
      result.payload_length = payload_len_in;
      result.error_code     = err;
   end

   assign status.halted = halted_ff;
   assign status.phase  = phase_ff;

endmodule

`default_nettype wire

[rtl/core/ndef_record_deframer.sv]
`default_nettype none

// NDEF record deframer: takes a record stream one byte per word on the req side and
// returns one word per byte on the rsp side, tagged with the record section it
// belongs to (header, type length, payload length, ID length, type, ID, payload, or
// discarded after a length error) together with the decoded flags, TNF and lengths.
// rsp_tlast marks the last byte of each record, and the next byte is taken as the
// next header. A length error stops parsing until a byte arrives with req_tuser set,
// which forces that byte to be parsed as a fresh header. The block sustains one word
// per clock while rsp_tready takes the results: a byte sits in an input register, the
// parser updates its state and forms the result from it, and the result lands in an
// output register, which drives rsp_tvalid and the rsp side. The two stages stall only
// while the output register holds a word that rsp_tready refuses; even then an empty
// input register still takes a word, so the block holds at most two words. The input
// and output registers are the only buffering; there is no memory.

`include "ndef_record_deframer_assert.svh"

module ndef_record_deframer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [7:0]                  req_tdata,  // [7:0] data_byte
   input  wire logic                        req_tuser,  // [0] restart
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [7:0] byte_echo, [10:8] name_format, [15:11] flags, [23:16] type_length,
   // [31:24] id_length, [63:32] payload_length, [65:64] error_code, rest zero
   output      logic [nrd_pkg::TDATA_W-1:0] rsp_tdata,
   output      logic                        rsp_tlast,  // record_end
   output      logic [nrd_pkg::TUSER_W-1:0] rsp_tuser   // [2:0] section
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_restart_ff, in_restart_in;
   logic       out_valid_ff, out_valid_in;
   nrd_pkg::rsp_type    out_ff, out_in;
   nrd_pkg::rsp_type    result;
   nrd_pkg::status_type status;

   logic advance;
   logic step;

   // The whole pipe moves whenever the output register is free or being taken.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_restart_in = in_restart_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (req_tready) begin
         in_valid_in   = req_tvalid;
         in_byte_in    = req_tdata;
         in_restart_in = req_tuser;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_restart_ff <= in_restart_in;
      out_ff        <= out_in;
   end

   nrd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .result    (result),
      .status    (status)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.record_end;
   assign rsp_tuser  = out_ff.section;
   assign rsp_tdata  = {6'd0, out_ff.error_code, out_ff.payload_length, out_ff.id_length,
                        out_ff.type_length, out_ff.flags, out_ff.name_format,
                        out_ff.byte_echo};

   // A word reporting a length error leaves the parser halted.
   `NRD_ASSERT_IMPL(a_err_halts, clock, reset,
      rsp_tvalid && out_ff.error_code != nrd_pkg::ERR_NONE, status.halted)
   // A discarded byte is only ever reported while the parser is halted.
   `NRD_ASSERT_IMPL(a_discard_halted, clock, reset,
      rsp_tvalid && out_ff.section == nrd_pkg::SEC_DISCARD, status.halted)
   // After the last byte of a record the parser waits for a header.
   `NRD_ASSERT_IMPL(a_end_header, clock, reset,
      rsp_tvalid && rsp_tlast, status.phase == nrd_pkg::SEC_HEADER && !status.halted)
   // A word held in the input stage while the output stalls is not lost: a word is still held afterwards.
   `NRD_ASSERT_NEXT(a_stall_keeps, clock, reset,
      in_valid_ff && rsp_tvalid && !rsp_tready, in_valid_ff || rsp_tvalid)

endmodule

`default_nettype wire
